// File: src/fpa_pkg.sv
// Shared constants and types for the Q17.14 fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 14;
  localparam int W         = 32;
  // quotient bits: a full word of integer bits plus the fraction
  localparam int DIV_W     = W + FRAC_BITS;

  localparam logic signed [W+1:0] ONE  = (W+2)'(1) <<< FRAC_BITS;
  localparam logic signed [W+1:0] HALF = ONE >>> 1;

  typedef enum logic [3:0] {
    FN_FROM_INT = 4'd0,
    FN_TRUNC    = 4'd1,
    FN_ROUND    = 4'd2,
    FN_ADD      = 4'd3,
    FN_ADD_INT  = 4'd4,
    FN_SUB      = 4'd5,
    FN_SUB_INT  = 4'd6,
    FN_MUL      = 4'd7,
    FN_MUL_INT  = 4'd8,
    FN_DIV      = 4'd9,
    FN_DIV_INT  = 4'd10,
    FN_INT_OVER = 4'd11,
    FN_LESS     = 4'd12
  } func_t;

  // side band that travels alongside the divider stages
  typedef struct packed {
    logic           valid;
    func_t          func;
    logic [W-1:0]   res;
    logic           less;
    logic           dz;
    logic           neg;
  } pipe_t;

endpackage

// File: src/fpa_if.sv
// Valid/ready channels for operation and result beats.
interface fpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [3:0]                     func;
  logic signed [fpa_pkg::W-1:0]   operand_a;
  logic signed [fpa_pkg::W-1:0]   operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic signed [fpa_pkg::W-1:0]   result;
  logic                           is_less;
  logic                           divide_by_zero;
  modport source (output valid, result, is_less, divide_by_zero, input ready);
  modport sink   (input valid, result, is_less, divide_by_zero, output ready);
endinterface

// File: src/fpa_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module fpa_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [fpa_pkg::W-1:0]  a,
  input  logic signed [fpa_pkg::W-1:0]  b,
  input  logic                          frac,
  output logic [fpa_pkg::W-1:0]         quo
);
  localparam int W  = fpa_pkg::W;
  localparam int DW = fpa_pkg::DIV_W;

  typedef struct packed {
    logic [W:0]    rem;
    logic [DW-1:0] dq;
  } step_t;

  function automatic step_t div_step(logic [W:0] rem, logic [DW-1:0] dq,
                                     logic [W-1:0] d);
    logic [W:0]   trial;
    logic [W+1:0] diff;
    step_t        s;
    trial = {rem[W-1:0], dq[DW-1]};
    diff  = {1'b0, trial} - {2'b00, d};
    if (!diff[W+1]) begin
      s.rem = diff[W:0];
      s.dq  = {dq[DW-2:0], 1'b1};
    end else begin
      s.rem = trial;
      s.dq  = {dq[DW-2:0], 1'b0};
    end
    return s;
  endfunction

  logic [W-1:0]  mag_a, mag_b;
  logic [DW-1:0] dvd;

  assign mag_a = a[W-1] ? W'(-a) : W'(a);
  assign mag_b = b[W-1] ? W'(-b) : W'(b);
  assign dvd   = frac ? {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}} : DW'(mag_a);

  logic [W:0]    rem [DW];
  logic [DW-1:0] dq  [DW];
  logic [W-1:0]  dvs [DW];

  for (genvar j = 0; j < DW; j++) begin : g_stage
    step_t s;
    if (j == 0) begin : g_first
      assign s = div_step('0, dvd, mag_b);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= s.rem;
          dq[j]  <= s.dq;
          dvs[j] <= mag_b;
        end
      end
    end else begin : g_next
      assign s = div_step(rem[j-1], dq[j-1], dvs[j-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= s.rem;
          dq[j]  <= s.dq;
          dvs[j] <= dvs[j-1];
        end
      end
    end
  end

  assign quo = dq[DW-1][W-1:0];
endmodule

// File: src/fpa_mul.sv
// Two-stage signed multiplier with fixed-point rescale toward zero.
module fpa_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [fpa_pkg::W-1:0]  a,
  input  logic signed [fpa_pkg::W-1:0]  b,
  output logic [fpa_pkg::W-1:0]         res_frac,
  output logic [fpa_pkg::W-1:0]         res_int
);
  localparam int W = fpa_pkg::W;

  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] biased;

  // bias negative products so the shift truncates toward zero
  assign biased = prod + (prod[2*W-1] ? (2*W)'(fpa_pkg::ONE - 1) : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= a * b;
      res_frac <= W'(biased >>> fpa_pkg::FRAC_BITS);
      res_int  <= prod[W-1:0];
    end
  end
endmodule

// File: src/fixed_point_17_14_alu.sv
// Top level of the pipelined Q17.14 fixed-point ALU.
// Usage:
//   req carries one operation per beat: func, operand_a, operand_b.
//   rsp returns exactly one beat per operation, in order: result,
//   is_less and divide_by_zero.
//   The path is one input register, one divider stage per quotient
//   bit and one output register.
//   The divider pipeline sets the depth; multiply results ride the
//   same pipeline so every operation has equal latency.
//   Throughput is one operation per cycle while rsp is not stalled.
//   A zero divisor on div, div_int or int_over_int gives result 0 and
//   divide_by_zero set.
//   When rsp stalls with a beat held, the whole pipeline freezes and
//   req.ready drops; nothing is lost or repeated.
//   Synchronous reset empties the pipeline; rsp.valid falls at once.
module fixed_point_17_14_alu (
  input  logic       clk,
  input  logic       rst,
  fpa_req_if.sink    req,
  fpa_rsp_if.source  rsp
);
  localparam int W  = fpa_pkg::W;
  localparam int FB = fpa_pkg::FRAC_BITS;
  localparam int DW = fpa_pkg::DIV_W;

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input register
  logic                 s0_valid;
  fpa_pkg::func_t       s0_func;
  logic signed [W-1:0]  s0_a, s0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func <= fpa_pkg::func_t'(req.func);
      s0_a    <= req.operand_a;
      s0_b    <= req.operand_b;
    end
  end

  // simple operations
  logic signed [W:0]    tr_sum;
  logic signed [W:0]    rd_t;
  logic signed [W+1:0]  rd_sum;
  logic [W-1:0]         b_sh;
  logic                 is_div;
  fpa_pkg::pipe_t       first;

  assign tr_sum = (W+1)'(s0_a) + (s0_a[W-1] ? (W+1)'(fpa_pkg::ONE - 1) : '0);
  assign rd_t   = (W+1)'(s0_a) + (s0_a[W-1] ? -(W+1)'(fpa_pkg::HALF)
                                            :  (W+1)'(fpa_pkg::HALF));
  assign rd_sum = (W+2)'(rd_t) + (rd_t[W] ? (fpa_pkg::ONE - 1) : '0);
  assign b_sh   = W'(s0_b) << FB;
  assign is_div = (s0_func == fpa_pkg::FN_DIV) || (s0_func == fpa_pkg::FN_DIV_INT)
               || (s0_func == fpa_pkg::FN_INT_OVER);

  always_comb begin
    first       = '0;
    first.valid = s0_valid;
    first.func  = s0_func;
    first.neg   = s0_a[W-1] ^ s0_b[W-1];
    first.dz    = is_div && (s0_b == '0);
    case (s0_func)
      fpa_pkg::FN_FROM_INT: first.res = W'(s0_a) << FB;
      fpa_pkg::FN_TRUNC:    first.res = W'(tr_sum >>> FB);
      fpa_pkg::FN_ROUND:    first.res = W'(rd_sum >>> FB);
      fpa_pkg::FN_ADD:      first.res = W'(s0_a) + W'(s0_b);
      fpa_pkg::FN_ADD_INT:  first.res = W'(s0_a) + b_sh;
      fpa_pkg::FN_SUB:      first.res = W'(s0_a) - W'(s0_b);
      fpa_pkg::FN_SUB_INT:  first.res = W'(s0_a) - b_sh;
      fpa_pkg::FN_LESS:     first.less = s0_a < s0_b;
      default:              first.res = '0;
    endcase
  end

  logic [W-1:0] mul_frac, mul_int, quo;

  fpa_mul u_mul (
    .clk      (clk),
    .en       (en),
    .a        (s0_a),
    .b        (s0_b),
    .res_frac (mul_frac),
    .res_int  (mul_int)
  );

  fpa_div u_div (
    .clk  (clk),
    .en   (en),
    .a    (s0_a),
    .b    (s0_b),
    .frac (s0_func != fpa_pkg::FN_DIV_INT),
    .quo  (quo)
  );

  fpa_pkg::pipe_t pipe [1:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[1] <= '0;
    end else if (en) begin
      pipe[1] <= first;
    end
  end

  for (genvar i = 1; i < DW; i++) begin : g_pipe
    fpa_pkg::pipe_t nxt;
    always_comb begin
      nxt = pipe[i];
      // multiplier output lines up with stage two
      if (i == 2) begin
        if (pipe[i].func == fpa_pkg::FN_MUL)     nxt.res = mul_frac;
        if (pipe[i].func == fpa_pkg::FN_MUL_INT) nxt.res = mul_int;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1] <= '0;
      end else if (en) begin
        pipe[i+1] <= nxt;
      end
    end
  end

  // merge quotient, then register the beat
  fpa_pkg::pipe_t last;
  logic           last_div;
  logic           out_valid;
  logic [W-1:0]   out_res;
  logic           out_less, out_dz;

  assign last     = pipe[DW];
  assign last_div = (last.func == fpa_pkg::FN_DIV) || (last.func == fpa_pkg::FN_DIV_INT)
                 || (last.func == fpa_pkg::FN_INT_OVER);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_less <= last.less;
      out_dz   <= last.dz;
      if (last_div) begin
        out_res <= last.dz ? '0 : (last.neg ? -quo : quo);
      end else begin
        out_res <= last.res;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result         = out_res;
  assign rsp.is_less        = out_less;
  assign rsp.divide_by_zero = out_dz;

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> rsp.result == '0)
    else $error("divide by zero beat with nonzero result");

  a_less_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.is_less |-> rsp.result == '0 && !rsp.divide_by_zero)
    else $error("less beat carries other fields");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready == (!rsp.valid || rsp.ready))
    else $error("input ready out of step with output stall");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !req.ready |=> $stable(pipe[DW]))
    else $error("pipeline advanced during stall");
endmodule

// File: sim/alu_checker.sv
// Checker for the fixed-point ALU: watches both channels, predicts results, compares.
module alu_checker (
  input  logic       clk,
  input  logic       rst,
  fpa_req_if.sink    req_mon,
  fpa_rsp_if.sink    rsp_mon,
  output int         errors,
  output int         pending,
  output logic       beat_seen
);

  typedef struct packed {
    logic [31:0] result;
    logic        is_less;
    logic        divide_by_zero;
  } alu_out_t;

  alu_out_t expected_q[$];
  int       mismatches;

  function automatic alu_out_t compute_alu(logic [3:0] fn, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_out_t          r;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] one;
    logic signed [63:0] half;
    logic signed [63:0] t;
    r    = '0;
    a64  = 64'(a);
    b64  = 64'(b);
    one  = 64'sd1 <<< fpa_pkg::FRAC_BITS;
    half = one >>> 1;
    case (fn)
      fpa_pkg::FN_FROM_INT: r.result = a << fpa_pkg::FRAC_BITS;
      fpa_pkg::FN_TRUNC:    r.result = 32'(a64 / one);
      fpa_pkg::FN_ROUND: begin
        t = (a64 >= 0) ? a64 + half : a64 - half;
        r.result = 32'(t / one);
      end
      fpa_pkg::FN_ADD:      r.result = a + b;
      fpa_pkg::FN_ADD_INT:  r.result = a + (b << fpa_pkg::FRAC_BITS);
      fpa_pkg::FN_SUB:      r.result = a - b;
      fpa_pkg::FN_SUB_INT:  r.result = a - (b << fpa_pkg::FRAC_BITS);
      fpa_pkg::FN_MUL:      r.result = 32'((a64 * b64) / one);
      fpa_pkg::FN_MUL_INT:  r.result = 32'(a64 * b64);
      fpa_pkg::FN_DIV, fpa_pkg::FN_INT_OVER: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = 32'((a64 * one) / b64);
      end
      fpa_pkg::FN_DIV_INT: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = 32'(a64 / b64);
      end
      fpa_pkg::FN_LESS:     r.is_less = (a < b);
      default:              r = '0;
    endcase
    return r;
  endfunction

  assign pending   = expected_q.size();
  assign beat_seen = (req_mon.valid && req_mon.ready) || (rsp_mon.valid && rsp_mon.ready);

  always_ff @(posedge clk) begin
    alu_out_t want;
    if (rst) begin
      errors     <= 0;
      mismatches = 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(compute_alu(req_mon.func, req_mon.operand_a, req_mon.operand_b));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          if (mismatches < 10) $display("unexpected result beat %h", rsp_mon.result);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (want.result !== rsp_mon.result || want.is_less !== rsp_mon.is_less ||
              want.divide_by_zero !== rsp_mon.divide_by_zero) begin
            errors <= errors + 1;
            if (mismatches < 10)
              $display("mismatch: expected %h/%b/%b got %h/%b/%b", want.result,
                       want.is_less, want.divide_by_zero, rsp_mon.result,
                       rsp_mon.is_less, rsp_mon.divide_by_zero);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
// Stimulus and verdict for the fixed-point ALU.
module testbench;

  localparam int LATENCY  = fpa_pkg::DIV_W + 2;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_LEN = 300;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  logic beat_seen;
  logic idle_free;
  logic hold_rsp;

  fpa_req_if req ();
  fpa_rsp_if rsp ();

  fixed_point_17_14_alu DUT (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  alu_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req.sink), .rsp_mon(rsp.sink),
    .errors(errors), .pending(pending), .beat_seen(beat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, except in quiet stretches and during the hold.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !hold_rsp && (idle_free || $urandom_range(99) >= 12);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (beat_seen) idle = 0;
      else idle++;
      if (idle >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'(int'($urandom_range(8)) - 4);
      3:       return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
      4:       return 32'(int'($urandom_range(8)) - 4) << fpa_pkg::FRAC_BITS;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(logic [3:0] fn, logic [31:0] a, logic [31:0] b, bit gaps);
    while (gaps && !idle_free && $urandom_range(99) < 12) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= fn;
    req.operand_a <= a;
    req.operand_b <= b;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  fn;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.func      <= '0;
    req.operand_a <= '0;
    req.operand_b <= '0;
    idle_free     <= 1'b0;
    hold_rsp      <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every opcode, field extremes, zero divisor, min over minus one, unused codes
    for (int f = 0; f < 16; f++)
      send_op(4'(f), 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_op(fpa_pkg::FN_DIV, 32'h0001_0000, 32'h0, 1'b0);
    send_op(fpa_pkg::FN_DIV_INT, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    send_op(fpa_pkg::FN_INT_OVER, 32'd7, 32'h0, 1'b0);
    send_op(fpa_pkg::FN_DIV_INT, 32'd7, 32'h0, 1'b0);
    send_op(fpa_pkg::FN_ROUND, 32'h0000_2000, 32'h0, 1'b0);
    send_op(fpa_pkg::FN_ROUND, 32'hffff_e000, 32'h0, 1'b0);
    send_op(fpa_pkg::FN_LESS, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_op(fpa_pkg::FN_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_op(fpa_pkg::FN_LESS, 32'hffff_ffff, 32'hffff_ffff, 1'b0);

    // sender pause until every result is back
    drain();

    // receiver holds off while the sender keeps offering beats
    hold_rsp <= 1'b1;
    fork
      begin
        repeat (HOLD_LEN) @(posedge clk);
        hold_rsp <= 1'b0;
      end
      for (int i = 0; i < 120; i++)
        send_op(4'($urandom_range(12)), pick_operand(), pick_operand(), 1'b0);
    join

    for (int i = 0; i < 600; i++) begin
      if (i == 200) idle_free <= 1'b1;
      if (i == 350) idle_free <= 1'b0;
      fn = ($urandom_range(49) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      a  = pick_operand();
      b  = ($urandom_range(19) == 0) ? 32'h0 : pick_operand();
      send_op(fn, a, b, 1'b1);
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
src/fpa_pkg.sv
src/fpa_if.sv
src/fpa_div.sv
src/fpa_mul.sv
src/fixed_point_17_14_alu.sv
sim/alu_checker.sv
sim/testbench.sv
